// File: sv/go_back_n_sender_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the go-back-N sender unit.
// Each check samples on the rising edge of clk and is held off during rst.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_UNIT_MACROS_SVH
`define GO_BACK_N_SENDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("go_back_n_sender_unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("go_back_n_sender_unit: next-cycle check failed");

`else

`define GBN_ASSERT_NOW(lbl, ante, cons)
`define GBN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared sizes, codes and types of the go-back-N sender unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  // Field widths.
  localparam int SEQ_W  = 32;
  localparam int ADDR_W = 16;
  localparam int LEN_W  = 8;
  localparam int REQ_W  = 2;

  // Window and wait queue sizes.
  localparam int WINDOW     = 4;
  localparam int WAIT_DEPTH = 16;

  localparam int WIN_CW  = $clog2(WINDOW + 1);
  localparam int WAIT_AW = $clog2((WAIT_DEPTH > 1) ? WAIT_DEPTH : 2);
  localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);

  localparam logic [WIN_CW-1:0]  WIN_FULL  = WIN_CW'(WINDOW);
  localparam logic [WIN_CW-1:0]  WIN_ALMOST = WIN_CW'(WINDOW - 1);
  localparam logic [WAIT_CW-1:0] WAIT_FULL = WAIT_CW'(WAIT_DEPTH);
  localparam logic [WAIT_AW-1:0] WAIT_LAST = WAIT_AW'(WAIT_DEPTH - 1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  // Result status codes.
  localparam logic ST_TRANSMIT = 1'b0;
  localparam logic ST_REFUSED  = 1'b1;

  // Frame descriptor.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  // Controls broadcast to every window cell.
  typedef struct packed {
    logic push;
    logic pop;
    logic rotate;
  } win_ctl_t;

endpackage

`default_nettype wire

// File: sv/gbn_req_if.sv
// ----------------------------------------------------------------------------
// gbn_req_if
// Request channel: send, ack and timeout words with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbn_req_if;
  import gbn_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SEQ_W-1:0]  frame_seq;
  logic [ADDR_W-1:0] frame_addr;
  logic [LEN_W-1:0]  frame_len;
  logic [SEQ_W-1:0]  ack_num;

  modport source (
    output valid, req_type, frame_seq, frame_addr, frame_len, ack_num,
    input  ready
  );

  modport sink (
    input  valid, req_type, frame_seq, frame_addr, frame_len, ack_num,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/gbn_rsp_if.sv
// ----------------------------------------------------------------------------
// gbn_rsp_if
// Result channel: frames to transmit or refusals, with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbn_rsp_if;
  import gbn_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  out_seq;
  logic [ADDR_W-1:0] out_addr;
  logic [LEN_W-1:0]  out_len;
  logic              status;
  logic              last;

  modport source (
    output valid, out_seq, out_addr, out_len, status, last,
    input  ready
  );

  modport sink (
    input  valid, out_seq, out_addr, out_len, status, last,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-N ARQ sender working on frame descriptors.
// ----------------------------------------------------------------------------
// Channels: req (sink) carries send, ack and timeout words; rsp (source)
// carries frames to transmit, or a refusal when the wait queue is full,
// with last set on the final word caused by each request.
// The unacknowledged window is a row of WINDOW cells, oldest frame in cell 0.
// Frames that do not fit wait in a RAM FIFO of WAIT_DEPTH entries.
// One request is worked at a time; req.ready is high only while idle,
// and the result register lets a new request enter while its word waits.
// Work after acceptance:
//   send    - queued, transmitted or refused,
//   ack     - retires each acknowledged frame, then moves frames
//            from the wait queue (RAM read then window load),
//   timeout - resends every window frame, oldest first.
// Each request is accepted in the idle state. The ack compare walks the
// window one cell a cycle; the wait queue RAM read sets the refill rate.
// Reset clears the window, the wait queue counters and the result valid flag;
// no clearing pass is needed. When rsp stalls, the result word holds and
// the engine waits before producing the next word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "go_back_n_sender_unit_macros.svh"

module go_back_n_sender_unit (
  input wire logic clk,
  input wire logic rst,
  gbn_req_if.sink  req,
  gbn_rsp_if.source rsp
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_RETIRE,
    S_FILL,
    S_FILL_LOAD,
    S_TIMEOUT
  } state_t;

  state_t state;
  state_t state_next;

  // Latched request.
  desc_t            cur_desc;
  logic [SEQ_W-1:0] cur_ack;

  // Window bookkeeping.
  logic [WIN_CW-1:0] win_count;
  logic [WIN_CW-1:0] rot_idx;
  win_ctl_t          win_ctl;
  desc_t             new_data;
  logic [WINDOW-1:0] win_valid;
  desc_t             win_data [WINDOW];
  logic [WINDOW-1:0] win_mask;

  // Wait queue.
  logic [WAIT_AW-1:0] wait_rd;
  logic [WAIT_AW-1:0] wait_wr;
  logic [WAIT_CW-1:0] wait_count;
  logic               wait_we;
  logic               wait_re;
  desc_t              wait_q;
  logic [DESC_W-1:0]  wait_q_bits;

  // Result word to load.
  logic  emit;
  desc_t emit_desc;
  logic  emit_status;
  logic  emit_last;
  logic  slot_free;
  logic  req_fire;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;
  assign wait_q    = desc_t'(wait_q_bits);

  // Row of window cells.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic  left_v;
    logic  right_v;
    desc_t right_d;

    if (i == 0) begin : g_first
      assign left_v = 1'b1;
    end else begin : g_mid
      assign left_v = win_valid[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_v = 1'b0;
      assign right_d = '0;
    end else begin : g_inner
      assign right_v = win_valid[i+1];
      assign right_d = win_data[i+1];
    end

    gbn_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (win_ctl),
      .left_valid  (left_v),
      .right_valid (right_v),
      .right_data  (right_d),
      .head_data   (win_data[0]),
      .new_data    (new_data),
      .valid       (win_valid[i]),
      .data        (win_data[i])
    );
  end

  // Wait queue storage.
  gbn_ram #(
    .WIDTH (DESC_W),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (wait_we),
    .wr_addr (wait_wr),
    .wr_data (cur_desc),
    .rd_en   (wait_re),
    .rd_addr (wait_rd),
    .rd_data (wait_q_bits)
  );

  // Sequencer controls for the current state.
  always_comb begin
    state_next  = state;
    win_ctl     = '0;
    new_data    = cur_desc;
    wait_we     = 1'b0;
    wait_re     = 1'b0;
    emit        = 1'b0;
    emit_desc   = '0;
    emit_status = ST_TRANSMIT;
    emit_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.req_type == REQ_SEND) begin
            state_next = S_SEND;
          end else if (req.req_type == REQ_ACK) begin
            state_next = S_RETIRE;
          end else if (req.req_type == REQ_TIMEOUT) begin
            state_next = S_TIMEOUT;
          end
        end
      end
      S_SEND: begin
        if (win_count != WIN_FULL) begin
          if (slot_free) begin
            win_ctl.push = 1'b1;
            emit         = 1'b1;
            emit_desc    = cur_desc;
            emit_last    = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (wait_count != WAIT_FULL) begin
          wait_we    = 1'b1;
          state_next = S_IDLE;
        end else if (slot_free) begin
          emit        = 1'b1;
          emit_status = ST_REFUSED;
          emit_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_RETIRE: begin
        if (win_valid[0] && (win_data[0].seq <= cur_ack)) begin
          win_ctl.pop = 1'b1;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if ((wait_count != '0) && (win_count != WIN_FULL)) begin
          wait_re    = 1'b1;
          state_next = S_FILL_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FILL_LOAD: begin
        // The fill count already excludes the word being loaded here.
        new_data = wait_q;
        if (slot_free) begin
          win_ctl.push = 1'b1;
          emit         = 1'b1;
          emit_desc    = wait_q;
          emit_last    = (win_count == WIN_ALMOST) || (wait_count == '0);
          state_next   = S_FILL;
        end
      end
      S_TIMEOUT: begin
        if (win_count == '0) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          win_ctl.rotate = 1'b1;
          emit           = 1'b1;
          emit_desc      = win_data[0];
          emit_last      = (rot_idx == win_count - WIN_CW'(1));
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      win_count  <= '0;
      rot_idx    <= '0;
      wait_rd    <= '0;
      wait_wr    <= '0;
      wait_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (win_ctl.push) begin
        win_count <= win_count + WIN_CW'(1);
      end else if (win_ctl.pop) begin
        win_count <= win_count - WIN_CW'(1);
      end

      if (req_fire) begin
        rot_idx <= '0;
      end else if (win_ctl.rotate) begin
        rot_idx <= rot_idx + WIN_CW'(1);
      end

      if (wait_we) begin
        wait_wr    <= (wait_wr == WAIT_LAST) ? '0 : wait_wr + WAIT_AW'(1);
        wait_count <= wait_count + WAIT_CW'(1);
      end else if (wait_re) begin
        wait_rd    <= (wait_rd == WAIT_LAST) ? '0 : wait_rd + WAIT_AW'(1);
        wait_count <= wait_count - WAIT_CW'(1);
      end

      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_desc.seq  <= req.frame_seq;
      cur_desc.addr <= req.frame_addr;
      cur_desc.len  <= req.frame_len;
      cur_ack       <= req.ack_num;
    end
    if (emit) begin
      rsp.out_seq  <= emit_desc.seq;
      rsp.out_addr <= emit_desc.addr;
      rsp.out_len  <= emit_desc.len;
      rsp.status   <= emit_status;
      rsp.last     <= emit_last;
    end
  end

  // Expected occupancy pattern of the cell row.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      win_mask[i] = (WIN_CW'(i) < win_count);
    end
  end

  // The occupied cells are exactly the oldest win_count cells.
  `GBN_ASSERT_NOW(a_win_packed, 1'b1, win_valid == win_mask)
  // A new result word is loaded only when the previous one has left.
  `GBN_ASSERT_NOW(a_emit_free, emit, slot_free)
  // The wait queue fill count never passes its depth.
  `GBN_ASSERT_NOW(a_wait_bound, 1'b1, wait_count <= WAIT_FULL)
  // A wait queue read is always followed by loading that word.
  `GBN_ASSERT_NEXT(a_fill_load, wait_re, state == S_FILL_LOAD)

endmodule

`default_nettype wire

// File: sv/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/gbn_cell.sv
// ----------------------------------------------------------------------------
// gbn_cell
// One window slot: holds a frame descriptor and shifts with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gbn_pkg::win_ctl_t ctl,
  input  wire logic             left_valid,
  input  wire logic             right_valid,
  input  wire gbn_pkg::desc_t   right_data,
  input  wire gbn_pkg::desc_t   head_data,
  input  wire gbn_pkg::desc_t   new_data,
  output logic                  valid,
  output gbn_pkg::desc_t        data
);
  import gbn_pkg::*;

  // Occupied cells stay packed toward the oldest end. A pop moves every
  // word one cell toward the head; a rotate does the same but the youngest
  // occupied cell takes the old head word; a push fills the first free cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end else if (ctl.push && !valid && left_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= right_data;
    end else if (ctl.rotate) begin
      if (right_valid) begin
        data <= right_data;
      end else if (valid) begin
        data <= head_data;
      end
    end else if (ctl.push && !valid && left_valid) begin
      data <= new_data;
    end
  end

endmodule

`default_nettype wire
